### hw/rtl/swtc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spot welder tick controller.
// No dependencies; imported by every module of the block.
package swtc_pkg;

   localparam int unsigned CNT_W    = 16;
   localparam int unsigned PULSE_W  = 10;
   localparam int unsigned BANK_W   = 20;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SCALE_W  = 8;
   localparam int unsigned CMP_W    = 16;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned NUM_BTN  = 4;

   localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
   localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd10;
   localparam logic [16:0]        PULSE_SCALE = 17'd100;

   // register index = paddr[4:2]
   localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
   localparam logic [2:0] REG_BANK_LIM  = 3'd1;
   localparam logic [2:0] REG_ADC_SCALE = 3'd2;
   localparam logic [2:0] REG_PULSE_MAX = 3'd3;
   localparam logic [2:0] REG_PULSE_MIN = 3'd4;
   localparam logic [2:0] REG_FLASH     = 3'd5;

   typedef struct packed {
      logic foot;
      logic charge;
      logic minus;
      logic plus;
   } btn_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_max_ms;
      logic [PULSE_W-1:0] pulse_min_ms;
      logic [CNT_W-1:0]   flash_ticks;
   } ctrl_cfg_type;

   typedef struct packed {
      logic             charge_relay;
      logic             discharge_relay;
      logic             start_led;
      logic             fire_pulse;
      logic [CMP_W-1:0] pulse_compare;
   } ctrl_res_type;

endpackage

### hw/rtl/swtc_debounce.sv
`timescale 1ns / 1ps
// One button lane: saturating run counter and debounced flag, emits the
// rising edge of the flag for the word being processed. Uses swtc_pkg.
module swtc_debounce (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       pressed,
   input  logic [swtc_pkg::CNT_W-1:0] threshold,
   output logic                       rise
);
   import swtc_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             flag_ff, flag_in;

   always_comb begin
      if (pressed) begin
         count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
         flag_in  = flag_ff;
      end else begin
         count_in = '0;
         flag_in  = 1'b0;
      end
      // a zero threshold matches the cleared counter of a release
      if (count_in == threshold) begin
         flag_in = 1'b1;
      end
      rise = flag_in & ~flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

### hw/rtl/swtc_ctrl.sv
`timescale 1ns / 1ps
// Charge/relay state, pulse length adjust, start LED flash sequence and
// timer compare value. Uses swtc_pkg.
module swtc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   over,
   input  swtc_pkg::btn_type      rise,
   input  swtc_pkg::ctrl_cfg_type cfg,
   output swtc_pkg::ctrl_res_type res
);
   import swtc_pkg::*;

   logic               charge_ff, charge_in;
   logic [1:0]         relay_ff, relay_in;   // bit0 charge, bit1 discharge
   logic               led_ff, led_in;
   logic               active_ff, active_in;
   logic [CNT_W-1:0]   fcount_ff, fcount_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;

   logic [PULSE_W:0]   plus_val;
   logic [PULSE_W-1:0] pulse_mid, dec_val;
   logic [16:0]        prod;
   logic               fire;

   always_comb begin
      charge_in = charge_ff;
      relay_in  = relay_ff;
      if (over) begin
         charge_in = 1'b0;
         relay_in  = 2'b10;
      end
      if (rise.charge) begin
         charge_in = over ? 1'b0 : ~charge_ff;
         relay_in  = charge_in ? 2'b01 : 2'b10;
      end

      plus_val  = {1'b0, pulse_ff} + 1'b1;
      pulse_mid = pulse_ff;
      if (rise.plus) begin
         pulse_mid = (plus_val >= {1'b0, cfg.pulse_max_ms}) ?
                     cfg.pulse_max_ms : plus_val[PULSE_W-1:0];
      end
      dec_val  = pulse_mid - 1'b1;
      pulse_in = pulse_mid;
      if (rise.minus) begin
         pulse_in = (pulse_mid == '0 || dec_val <= cfg.pulse_min_ms) ?
                    cfg.pulse_min_ms : dec_val;
      end

      led_in    = led_ff;
      active_in = active_ff;
      if (rise.foot) begin
         led_in    = 1'b1;
         active_in = 1'b1;
      end
      fcount_in = (active_in && fcount_ff != CNT_MAX) ? fcount_ff + 1'b1 : fcount_ff;
      fire      = 1'b0;
      if (fcount_in >= cfg.flash_ticks) begin
         active_in = 1'b0;
         fcount_in = '0;
         led_in    = 1'b0;
         fire      = 1'b1;
      end

      prod = {7'd0, pulse_in} * PULSE_SCALE;

      res.charge_relay    = relay_in[0];
      res.discharge_relay = relay_in[1];
      res.start_led       = led_in;
      res.fire_pulse      = fire;
      res.pulse_compare   = prod[16] ? '1 : prod[CMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ff <= 1'b0;
         relay_ff  <= 2'b00;
         led_ff    <= 1'b0;
         active_ff <= 1'b0;
         fcount_ff <= '0;
         pulse_ff  <= PULSE_RESET;
      end else if (step) begin
         charge_ff <= charge_in;
         relay_ff  <= relay_in;
         led_ff    <= led_in;
         active_ff <= active_in;
         fcount_ff <= fcount_in;
         pulse_ff  <= pulse_in;
      end
   end

endmodule

### hw/rtl/spot_welder_tick_controller_top.sv
`timescale 1ns / 1ps
// Top level of the spot welder tick controller: input register, CSRs, bank
// voltage, result register. Uses swtc_pkg, swtc_debounce and swtc_ctrl.
//
// Usage:
//   req_* carries one tick word: ADC sample and four button levels.
//   rsp_* returns one word per tick: bank millivolts, relay drives, LED,
//   fire strobe and timer compare value, all after that tick's update.
//   A word is taken when valid is high and stall is low.
//   An accepted word goes into the input register, then into the result
//   register, which raises rsp_valid; a held result can delay that move.
//   Throughput is one word per cycle while rsp_stall is low, set by the
//   single combinational pass from the input register to the result
//   register, where the per-tick state is also updated.
//   When rsp_stall is high the result word holds; the input register still
//   takes one more word, after which req_stall rises until the result moves.
//   CSRs sit on an APB port at byte address 4*index and can be read back;
//   write them only while no word is in flight.
//   Synchronous reset empties both registers, loads the CSR defaults and
//   clears the debounce, charge and flash state; pulse length restarts
//   at 10 ms with both relays open.
module spot_welder_tick_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swtc_pkg::SAMPLE_W-1:0] req_adc_sample,
   input  logic                          req_plus_pressed,
   input  logic                          req_minus_pressed,
   input  logic                          req_charge_pressed,
   input  logic                          req_foot_pressed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [swtc_pkg::BANK_W-1:0]   rsp_bank_mv,
   output logic                          rsp_charge_relay,
   output logic                          rsp_discharge_relay,
   output logic                          rsp_start_led,
   output logic                          rsp_fire_pulse,
   output logic [swtc_pkg::CMP_W-1:0]    rsp_pulse_compare,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swtc_pkg::ADDR_W-1:0]   paddr,
   input  logic [swtc_pkg::DATA_W-1:0]   pwdata,
   output logic [swtc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import swtc_pkg::*;

   // configuration registers
   logic [CNT_W-1:0]   debounce_ff;
   logic [BANK_W-1:0]  limit_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [PULSE_W-1:0] pmax_ff, pmin_ff;
   logic [CNT_W-1:0]   flash_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   // input register
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   btn_type             in_btn_ff, btn_now;
   logic                advance;

   // result register
   logic                rsp_valid_ff;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   ctrl_res_type        res_ff, res_in;

   btn_type             rise;
   ctrl_cfg_type        ctrl_cfg;
   logic                over;

   assign pready  = 1'b1;
   assign csr_idx = paddr[ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= 16'd50;
         limit_ff    <= 20'd16000;
         scale_ff    <= 8'd8;
         pmax_ff     <= 10'd100;
         pmin_ff     <= 10'd1;
         flash_ff    <= 16'd500;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_DEBOUNCE:  debounce_ff <= pwdata[CNT_W-1:0];
            REG_BANK_LIM:  limit_ff    <= pwdata[BANK_W-1:0];
            REG_ADC_SCALE: scale_ff    <= pwdata[SCALE_W-1:0];
            REG_PULSE_MAX: pmax_ff     <= pwdata[PULSE_W-1:0];
            REG_PULSE_MIN: pmin_ff     <= pwdata[PULSE_W-1:0];
            REG_FLASH:     flash_ff    <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DEBOUNCE:  prdata = {16'd0, debounce_ff};
         REG_BANK_LIM:  prdata = {12'd0, limit_ff};
         REG_ADC_SCALE: prdata = {24'd0, scale_ff};
         REG_PULSE_MAX: prdata = {22'd0, pmax_ff};
         REG_PULSE_MIN: prdata = {22'd0, pmin_ff};
         REG_FLASH:     prdata = {16'd0, flash_ff};
         default:       prdata = '0;
      endcase
   end

   // pipeline control
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign btn_now.plus   = req_plus_pressed;
   assign btn_now.minus  = req_minus_pressed;
   assign btn_now.charge = req_charge_pressed;
   assign btn_now.foot   = req_foot_pressed;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_adc_sample;
         in_btn_ff    <= btn_now;
      end
   end

   // bank voltage: 12 x 8 bit product fits the 20 bit field exactly
   assign bank_in = {8'd0, in_sample_ff} * {12'd0, scale_ff};
   assign over    = bank_in > limit_ff;

   swtc_debounce u_db_plus (
      .clock(clock), .reset(reset), .step(advance),
      .pressed(in_btn_ff.plus), .threshold(debounce_ff), .rise(rise.plus)
   );
   swtc_debounce u_db_minus (
      .clock(clock), .reset(reset), .step(advance),
      .pressed(in_btn_ff.minus), .threshold(debounce_ff), .rise(rise.minus)
   );
   swtc_debounce u_db_charge (
      .clock(clock), .reset(reset), .step(advance),
      .pressed(in_btn_ff.charge), .threshold(debounce_ff), .rise(rise.charge)
   );
   swtc_debounce u_db_foot (
      .clock(clock), .reset(reset), .step(advance),
      .pressed(in_btn_ff.foot), .threshold(debounce_ff), .rise(rise.foot)
   );

   assign ctrl_cfg.pulse_max_ms = pmax_ff;
   assign ctrl_cfg.pulse_min_ms = pmin_ff;
   assign ctrl_cfg.flash_ticks  = flash_ff;

   swtc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .step (advance),
      .over (over),
      .rise (rise),
      .cfg  (ctrl_cfg),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bank_ff <= bank_in;
         res_ff  <= res_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bank_mv         = bank_ff;
   assign rsp_charge_relay    = res_ff.charge_relay;
   assign rsp_discharge_relay = res_ff.discharge_relay;
   assign rsp_start_led       = res_ff.start_led;
   assign rsp_fire_pulse      = res_ff.fire_pulse;
   assign rsp_pulse_compare   = res_ff.pulse_compare;

   // the relays never close together
   a_relay_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(res_ff.charge_relay && res_ff.discharge_relay))
      else $error("charge and discharge relays closed together");

   // the fire strobe ends the flash, so the LED is dark in that word
   a_fire_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.fire_pulse) |-> !res_ff.start_led)
      else $error("start LED lit in the fire word");

   // a word that advances out of the input register becomes a valid result word
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for spot_welder_tick_controller_top: tick words in,
// per-tick controller state predicted in the bench and checked word by word.
// Depends on swtc_pkg and the RTL of the block only.
module tb_top;
   import swtc_pkg::*;

   localparam int unsigned MS_TO_COMPARE = 100;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned HOLDOFF_LEN   = 300;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] adc_sample;
      btn_type             buttons;
   } tick_word_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank_mv;
      ctrl_res_type      ctl;
   } tick_result_type;

   // directed ticks: {adc_sample, foot, charge, minus, plus}
   localparam logic [15:0] DIRECTED_TICKS [25] = '{
      {12'd0,    4'b0000},  // all quiet
      {12'd4095, 4'b0100},  // charge edge while over the limit stays off
      {12'd0,    4'b0000},
      {12'd100,  4'b0100},  // charge on
      {12'd100,  4'b0100},  // held, no new edge
      {12'd2001, 4'b0000},  // just over the limit
      {12'd2000, 4'b0100},  // exactly at the limit is not over
      {12'd0,    4'b0001},  // plus
      {12'd0,    4'b0000},
      {12'd0,    4'b0001},  // plus reaches max
      {12'd0,    4'b0000},
      {12'd0,    4'b0001},  // plus held at max
      {12'd0,    4'b0011},  // minus edge, plus still held
      {12'd0,    4'b0000},
      {12'd0,    4'b0011},  // plus and minus edges together
      {12'd0,    4'b0000},
      {12'd0,    4'b0010},
      {12'd0,    4'b0000},
      {12'd0,    4'b0010},  // minus clamps at min
      {12'd4095, 4'b1000},  // footswitch starts the flash
      {12'd4095, 4'b0000},
      {12'd4095, 4'b1000},  // footswitch again mid flash, count carries on
      {12'd0,    4'b0000},
      {12'd4095, 4'b1111},
      {12'd0,    4'b0000}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_adc_sample = '0;
   logic                req_plus_pressed = 1'b0;
   logic                req_minus_pressed = 1'b0;
   logic                req_charge_pressed = 1'b0;
   logic                req_foot_pressed = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BANK_W-1:0]   rsp_bank_mv;
   logic                rsp_charge_relay;
   logic                rsp_discharge_relay;
   logic                rsp_start_led;
   logic                rsp_fire_pulse;
   logic [CMP_W-1:0]    rsp_pulse_compare;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   spot_welder_tick_controller_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_adc_sample(req_adc_sample), .req_plus_pressed(req_plus_pressed),
      .req_minus_pressed(req_minus_pressed), .req_charge_pressed(req_charge_pressed),
      .req_foot_pressed(req_foot_pressed),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bank_mv(rsp_bank_mv), .rsp_charge_relay(rsp_charge_relay),
      .rsp_discharge_relay(rsp_discharge_relay), .rsp_start_led(rsp_start_led),
      .rsp_fire_pulse(rsp_fire_pulse), .rsp_pulse_compare(rsp_pulse_compare),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the CSRs, written only while the block is idle
   logic [CNT_W-1:0]   cfg_debounce   = 16'd50;
   logic [BANK_W-1:0]  cfg_bank_limit = 20'd16000;
   logic [SCALE_W-1:0] cfg_adc_scale  = 8'd8;
   logic [PULSE_W-1:0] cfg_pulse_max  = 10'd100;
   logic [PULSE_W-1:0] cfg_pulse_min  = 10'd1;
   logic [CNT_W-1:0]   cfg_flash      = 16'd500;

   // controller state as predicted, owned by the driver
   logic [CNT_W-1:0]   press_run [NUM_BTN];
   logic [NUM_BTN-1:0] held_flags;
   logic               charging;
   logic [1:0]         relay_drive;  // bit0 charge, bit1 discharge
   logic               led_lit;
   logic               flashing;
   logic [CNT_W-1:0]   flash_elapsed;
   logic [PULSE_W-1:0] pulse_len;

   tick_word_type   pending_ticks [$];
   tick_result_type expected_results [$];
   tick_word_type   offered_tick;
   pace_type        pace = PACE_SLOW_SINK;
   bit           holdoff_req = 1'b0;
   bit           holdoff_taken = 1'b0;
   int unsigned  holdoff_left = 0;
   int unsigned  result_faults = 0;
   int unsigned  csr_faults = 0;
   int unsigned  results_checked = 0;
   int unsigned  phases_run = 0;
   int unsigned  quiet_cycles = 0;

   function automatic tick_result_type predict_tick(input tick_word_type w);
      tick_result_type    r;
      logic [BANK_W-1:0]  bank;
      logic               over;
      logic [NUM_BTN-1:0] prev_flags;
      logic [NUM_BTN-1:0] rising;
      logic [NUM_BTN-1:0] pressed;
      logic [PULSE_W:0]   longer;
      logic [16:0]        cmp;
      r = '0;
      pressed = w.buttons;
      bank = BANK_W'(w.adc_sample) * BANK_W'(cfg_adc_scale);
      over = bank > cfg_bank_limit;
      if (over) begin
         charging = 1'b0;
         relay_drive = 2'b10;
      end
      prev_flags = held_flags;
      for (int i = 0; i < NUM_BTN; i++) begin
         if (pressed[i]) begin
            if (press_run[i] != CNT_MAX) press_run[i] = press_run[i] + 1'b1;
         end else begin
            press_run[i] = '0;
            held_flags[i] = 1'b0;
         end
         // with a zero threshold a released button matches too
         if (press_run[i] == cfg_debounce) held_flags[i] = 1'b1;
      end
      rising = held_flags & ~prev_flags;
      if (rising[2]) begin
         charging = over ? 1'b0 : ~charging;
         relay_drive = charging ? 2'b01 : 2'b10;
      end
      if (rising[0]) begin
         longer = {1'b0, pulse_len} + 1'b1;
         if (longer >= {1'b0, cfg_pulse_max}) longer = {1'b0, cfg_pulse_max};
         pulse_len = longer[PULSE_W-1:0];
      end
      if (rising[1]) begin
         if (pulse_len == '0 || pulse_len - 1'b1 <= cfg_pulse_min) pulse_len = cfg_pulse_min;
         else pulse_len = pulse_len - 1'b1;
      end
      if (rising[3]) begin
         led_lit = 1'b1;
         flashing = 1'b1;
      end
      if (flashing && flash_elapsed != CNT_MAX) flash_elapsed = flash_elapsed + 1'b1;
      if (flash_elapsed >= cfg_flash) begin
         flashing = 1'b0;
         flash_elapsed = '0;
         led_lit = 1'b0;
         r.ctl.fire_pulse = 1'b1;
      end
      cmp = 17'(pulse_len) * 17'(MS_TO_COMPARE);
      r.bank_mv = bank;
      r.ctl.charge_relay = relay_drive[0];
      r.ctl.discharge_relay = relay_drive[1];
      r.ctl.start_led = led_lit;
      r.ctl.pulse_compare = (cmp > 17'hFFFF) ? 16'hFFFF : cmp[15:0];
      return r;
   endfunction

   function automatic bit roll(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         result_faults++;
      end
   endfunction

   // tick driver
   always @(posedge clock) begin : drive_ticks
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < NUM_BTN; i++) press_run[i] = '0;
         held_flags = '0;
         charging = 1'b0;
         relay_drive = 2'b00;
         led_lit = 1'b0;
         flashing = 1'b0;
         flash_elapsed = '0;
         pulse_len = PULSE_RESET;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(predict_tick(offered_tick));
         if (!(req_valid && req_stall)) begin
            if (pending_ticks.size() != 0 &&
                !roll(pace == PACE_SLOW_SINK ? 37 : pace == PACE_SLOW_SOURCE ? 50 : 0)) begin
               offered_tick = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_adc_sample <= offered_tick.adc_sample;
               req_plus_pressed <= offered_tick.buttons.plus;
               req_minus_pressed <= offered_tick.buttons.minus;
               req_charge_pressed <= offered_tick.buttons.charge;
               req_foot_pressed <= offered_tick.buttons.foot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : watch_results
      tick_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               result_faults++;
            end else begin
               want = expected_results.pop_front();
               check_field("bank_mv", want.bank_mv, rsp_bank_mv);
               check_field("charge_relay", 20'(want.ctl.charge_relay),
                           20'(rsp_charge_relay));
               check_field("discharge_relay", 20'(want.ctl.discharge_relay),
                           20'(rsp_discharge_relay));
               check_field("start_led", 20'(want.ctl.start_led), 20'(rsp_start_led));
               check_field("fire_pulse", 20'(want.ctl.fire_pulse), 20'(rsp_fire_pulse));
               check_field("pulse_compare", 20'(want.ctl.pulse_compare),
                           20'(rsp_pulse_compare));
               results_checked++;
            end
         end
         if (holdoff_req && !holdoff_taken) begin
            holdoff_taken = 1'b1;
            holdoff_left = HOLDOFF_LEN;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= roll(pace == PACE_SLOW_SINK ? 50 : pace == PACE_SLOW_SOURCE ? 37 : 0);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [DATA_W-1:0] shadow_value(input logic [2:0] idx);
      case (idx)
         REG_DEBOUNCE:  return DATA_W'(cfg_debounce);
         REG_BANK_LIM:  return DATA_W'(cfg_bank_limit);
         REG_ADC_SCALE: return DATA_W'(cfg_adc_scale);
         REG_PULSE_MAX: return DATA_W'(cfg_pulse_max);
         REG_PULSE_MIN: return DATA_W'(cfg_pulse_min);
         default:       return DATA_W'(cfg_flash);
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_DEBOUNCE:  cfg_debounce = value[CNT_W-1:0];
         REG_BANK_LIM:  cfg_bank_limit = value[BANK_W-1:0];
         REG_ADC_SCALE: cfg_adc_scale = value[SCALE_W-1:0];
         REG_PULSE_MAX: cfg_pulse_max = value[PULSE_W-1:0];
         REG_PULSE_MIN: cfg_pulse_min = value[PULSE_W-1:0];
         REG_FLASH:     cfg_flash = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_verify(input logic [2:0] idx);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== shadow_value(idx)) begin
         $error("register %0d readback: expected %0h, got %0h", idx, shadow_value(idx), prdata);
         csr_faults++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input int unsigned db, input int unsigned lim,
                              input int unsigned scale, input int unsigned pmax,
                              input int unsigned pmin, input int unsigned flash,
                              input pace_type p);
      wait_drained();
      pace = p;
      csr_write(REG_DEBOUNCE, db);
      csr_write(REG_BANK_LIM, lim);
      csr_write(REG_ADC_SCALE, scale);
      csr_write(REG_PULSE_MAX, pmax);
      csr_write(REG_PULSE_MIN, pmin);
      csr_write(REG_FLASH, flash);
      for (int i = 0; i <= REG_FLASH; i++) csr_verify(3'(i));
      phases_run++;
      @(negedge clock);
   endtask

   // Buttons move in runs: presses mostly long enough to reach a threshold of up to 64,
   // short releases, plus a sprinkling of one-tick glitches.
   task automatic queue_random(input int unsigned n, input bit squeeze);
      int unsigned left [NUM_BTN];
      logic [NUM_BTN-1:0] level;
      int unsigned span;
      tick_word_type w;
      level = '0;
      for (int i = 0; i < NUM_BTN; i++) left[i] = 0;
      span = (cfg_debounce > 64) ? 64 : cfg_debounce;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < NUM_BTN; i++) begin
            if (left[i] == 0) begin
               level[i] = ~level[i];
               if (!level[i]) left[i] = $urandom_range(1, 3);
               else if (roll(70)) left[i] = span + $urandom_range(0, 3);
               else left[i] = $urandom_range(1, span + 1);
               if (left[i] == 0) left[i] = 1;
            end
            left[i]--;
         end
         w.buttons = level;
         if (roll(10)) w.buttons[$urandom_range(0, NUM_BTN - 1)] ^= 1'b1;
         if (roll(6)) w.adc_sample = roll(50) ? '0 : '1;
         else w.adc_sample = SAMPLE_W'($urandom_range(0, 4095));
         pending_ticks.push_back(w);
      end
      if (squeeze) holdoff_req = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      reconfigure(1, 16000, 8, 12, 9, 3, PACE_SLOW_SINK);
      foreach (DIRECTED_TICKS[i]) pending_ticks.push_back(tick_word_type'(DIRECTED_TICKS[i]));

      reconfigure(2, 16000, 8, 20, 1, 4, PACE_SLOW_SINK);
      queue_random(250, 1'b0);
      // zero debounce and zero flash, limit never reached
      reconfigure(0, 1048575, 255, 1023, 0, 0, PACE_SLOW_SINK);
      queue_random(200, 1'b0);
      reconfigure(3, 0, 0, 5, 5, 1, PACE_SLOW_SINK);
      queue_random(200, 1'b0);
      // crossed clamps, nearly always over the limit, long result hold-off
      reconfigure(1, 0, 255, 1, 655, 2, PACE_SLOW_SOURCE);
      queue_random(250, 1'b1);
      reconfigure(65535, 500, 1, 655, 600, 65535, PACE_SLOW_SOURCE);
      queue_random(150, 1'b0);
      // min above 655 pushes the compare into saturation
      reconfigure(4, 20000, 8, 1023, 700, 7, PACE_SLOW_SOURCE);
      queue_random(300, 1'b0);
      reconfigure(2, 8000, 4, 100, 1, 10, PACE_FULL);
      queue_random(250, 1'b0);
      reconfigure(50, 16000, 8, 100, 1, 500, PACE_FULL);
      queue_random(200, 1'b0);

      wait_drained();
      $display("Checked %0d result words across %0d register settings,", results_checked,
               phases_run);
      $display("with sender and receiver gaps and a %0d-cycle result hold-off.", HOLDOFF_LEN);
      if (result_faults == 0 && csr_faults == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
